>>> src/smx_pkg.sv
// shared types, constants and helpers for the stack machine executor
// no dependencies; imported by every module of the block except smx_ram
`timescale 1ns / 1ps
`default_nettype none

package smx_pkg;

	// default sizes
	localparam int DEF_STACK_DEPTH   = 256;
	localparam int DEF_PROGRAM_DEPTH = 128;
	localparam int DEF_FRAC_BITS     = 16;

	// field widths
	localparam int DATA_W   = 32;
	localparam int OP_W     = 4;
	localparam int CFG_W    = 7;
	localparam int CFG_IDX_W = 1;
	localparam int IP_W     = 33;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_PC    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_END = 1'b1;

	// opcodes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 4'd0,
		OP_ADD    = 4'd1,
		OP_SUB    = 4'd2,
		OP_MUL    = 4'd3,
		OP_DIV    = 4'd4,
		OP_STOREL = 4'd5,
		OP_LOADL  = 4'd6,
		OP_PRINT  = 4'd7,
		OP_ENTRY  = 4'd8,
		OP_RET    = 4'd9,
		OP_FRAME  = 4'd10,
		OP_CALL   = 4'd11,
		OP_POPR   = 4'd12,
		OP_STOREA = 4'd13,
		OP_LOADA  = 4'd14
	} op_t;

	// error codes
	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_OP    = 2'd1,
		ERR_STACK = 2'd2,
		ERR_DIV   = 2'd3
	} err_t;

	// back end sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_RA,
		S_RB,
		S_RC,
		S_CAP,
		S_EX,
		S_MUL,
		S_DIV
	} state_t;

	// classified instruction word held in the queue
	typedef struct packed {
		op_t                       op;
		logic signed [DATA_W-1:0]  operand;
		logic signed [IP_W-1:0]    ip;
		logic                      pop_print;
	} item_t;

	// configuration seen by the back end
	typedef struct packed {
		logic             pc_load;
		logic [CFG_W-1:0] pc_value;
		logic [CFG_W-1:0] program_end;
	} cfg_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[DATA_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

>>> src/smx_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module smx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> src/smx_div.sv
// iterative fixed-point divider, one quotient bit per cycle, saturating
// depends on smx_pkg
`timescale 1ns / 1ps
`default_nettype none

module smx_div #(
	parameter int FRAC_BITS = smx_pkg::DEF_FRAC_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [smx_pkg::DATA_W-1:0]  dividend,
	input  wire logic signed [smx_pkg::DATA_W-1:0]  divisor,
	output logic                                    done,
	output logic signed [smx_pkg::DATA_W-1:0]       quotient
);
	import smx_pkg::*;

	localparam int NW = DATA_W + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);
	localparam int QX = NW + 1;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [NW-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic          neg_q;

	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;
	logic [DATA_W:0]   trial;
	logic              fits;
	logic [QX-1:0]     quo_x;

	// operand magnitudes
	assign mag_a = dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
	assign mag_b = divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);

	// restoring step
	assign trial = {rem_q, num_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NW'(mag_a) << FRAC_BITS;
			den_q <= mag_b;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? DATA_W'(trial - {1'b0, den_q}) : trial[DATA_W-1:0];
		end
	end

	// sign and saturation
	assign quo_x = QX'(quo_q);
	always_comb begin
		if (neg_q) begin
			if (quo_x > (QX'(1) << (DATA_W - 1))) begin
				quotient = 32'sh8000_0000;
			end else begin
				quotient = -$signed(quo_q[DATA_W-1:0]);
			end
		end else begin
			if (quo_x > ((QX'(1) << (DATA_W - 1)) - QX'(1))) begin
				quotient = 32'sh7FFF_FFFF;
			end else begin
				quotient = $signed(quo_q[DATA_W-1:0]);
			end
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

>>> src/smx_front.sv
// front end: takes instruction words, classifies them, two-entry queue
// depends on smx_pkg
`timescale 1ns / 1ps
`default_nettype none

module smx_front #(
	parameter int FRAC_BITS = smx_pkg::DEF_FRAC_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [smx_pkg::OP_W-1:0]           cmd,
	input  wire logic signed [smx_pkg::DATA_W-1:0]  operand,
	output logic                                    q_valid,
	output smx_pkg::item_t                          q_item,
	input  wire logic                               q_pop
);
	import smx_pkg::*;

	localparam logic [IP_W-1:0]   FMASK   = (IP_W'(1) << FRAC_BITS) - IP_W'(1);
	localparam logic [DATA_W-1:0] NEG_ONE = ~((DATA_W'(1) << FRAC_BITS) - DATA_W'(1));

	item_t       ent_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	item_t       cls;
	logic signed [IP_W-1:0] biased;

	// integer part, truncated toward zero
	assign biased = IP_W'(operand) + (operand[DATA_W-1] ? $signed(FMASK) : $signed(IP_W'(0)));

	always_comb begin
		cls.op        = op_t'(cmd);
		cls.operand   = operand;
		cls.ip        = biased >>> FRAC_BITS;
		cls.pop_print = operand == NEG_ONE;
	end

	assign in_stall = cnt_q == 2'd2;
	assign push     = in_valid && !in_stall;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = ent_q[rd_ptr_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

endmodule

`default_nettype wire

>>> src/smx_back.sv
// back end: executes queued instructions against the value stack
// depends on smx_pkg, smx_ram, smx_div
`timescale 1ns / 1ps
`default_nettype none

module smx_back #(
	parameter int STACK_DEPTH   = smx_pkg::DEF_STACK_DEPTH,
	parameter int PROGRAM_DEPTH = smx_pkg::DEF_PROGRAM_DEPTH,
	parameter int FRAC_BITS     = smx_pkg::DEF_FRAC_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                q_valid,
	input  wire smx_pkg::item_t                      q_item,
	output logic                                     q_pop,
	input  wire smx_pkg::cfg_t                       cfg,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [$clog2(PROGRAM_DEPTH)-1:0]         next_pc,
	output logic                                     print_valid,
	output logic signed [smx_pkg::DATA_W-1:0]        print_value,
	output logic                                     halted,
	output logic [1:0]                               error_code
);
	import smx_pkg::*;

	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int SW  = $clog2(STACK_DEPTH + 1);
	localparam int PW  = $clog2(PROGRAM_DEPTH);
	localparam int XW  = 36;
	localparam int EW  = PW + CFG_W + 1;
	localparam logic signed [XW-1:0] DEPTHX = XW'(STACK_DEPTH);

	state_t state_q, state_n;

	// architectural state
	logic [SW-1:0]     sp_q, fp_q;
	logic [PW-1:0]     pc_q;
	logic [DATA_W-1:0] lp_q;
	logic              halt_q;

	// work registers
	item_t             item_q;
	logic [DATA_W-1:0] a_q, b_q, c_q;
	logic [AW-1:0]     ra_q, rb_q, rc_q, wa_q;
	logic [1:0]        nrd_q;
	logic signed [63:0] prod_q;

	// result register
	logic              out_valid_q;
	logic [PW-1:0]     out_pc_q;
	logic              out_print_q;
	logic [DATA_W-1:0] out_pv_q;
	logic              out_halt_q;
	err_t              out_err_q;

	// stack memory
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;

	// divider
	logic              div_start;
	logic              div_done;
	logic signed [DATA_W-1:0] div_q;

	// decode
	logic signed [XW-1:0] spx, fpx, ipx, la, nsp_f, nsp_p;
	logic              la_ok, full;
	logic [SW-1:0]     sp_m1, sp_m2, fp_m1, fp_m2;
	err_t              dec_err;
	logic [1:0]        dec_nrd;
	logic [AW-1:0]     dec_ra, dec_rb, dec_rc, dec_wa;
	logic              dec_read;

	// commit
	logic              cm_do, seq;
	logic [SW-1:0]     sp_n, fp_n;
	logic [PW-1:0]     pc_n;
	logic [DATA_W-1:0] lp_n;
	logic              halt_n, printed;
	logic [DATA_W-1:0] pv;
	err_t              err;
	logic signed [DATA_W-1:0] res;
	logic [PW:0]       npc;
	logic              link_bad;
	logic              out_take;

	smx_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	smx_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend($signed(b_q)),
		.divisor ($signed(a_q)),
		.done    (div_done),
		.quotient(div_q)
	);

	assign out_take = out_valid_q && !out_stall;
	assign q_pop    = (state_q == S_IDLE) && q_valid && (!out_valid_q || out_take);

	// address arithmetic for the held instruction
	always_comb begin
		spx   = XW'($signed({1'b0, sp_q}));
		fpx   = XW'($signed({1'b0, fp_q}));
		ipx   = XW'($signed(item_q.ip));
		la    = (item_q.op == OP_STOREA || item_q.op == OP_LOADA) ?
			fpx - ipx - XW'(3) : fpx + ipx;
		la_ok = la >= XW'(0) && la < DEPTHX;
		full  = spx >= DEPTHX;
		nsp_f = spx + XW'(1) + ipx;
		nsp_p = spx - ipx;
		sp_m1 = sp_q - SW'(1);
		sp_m2 = sp_q - SW'(2);
		fp_m1 = fp_q - SW'(1);
		fp_m2 = fp_q - SW'(2);
	end

	// stack checks and read plan
	always_comb begin
		dec_err = ERR_NONE;
		dec_nrd = 2'd0;
		dec_ra  = sp_m1[AW-1:0];
		dec_rb  = sp_m2[AW-1:0];
		dec_rc  = fp_m2[AW-1:0];
		dec_wa  = sp_q[AW-1:0];
		case (item_q.op)
			OP_PUSH, OP_CALL: begin
				if (full) dec_err = ERR_STACK;
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (sp_q < SW'(2)) dec_err = ERR_STACK;
				dec_nrd = 2'd2;
				dec_wa  = sp_m2[AW-1:0];
			end
			OP_STOREL, OP_STOREA: begin
				if (sp_q == '0 || !la_ok) dec_err = ERR_STACK;
				dec_nrd = 2'd1;
				dec_wa  = la[AW-1:0];
			end
			OP_LOADL, OP_LOADA: begin
				if (full || !la_ok) dec_err = ERR_STACK;
				dec_nrd = 2'd1;
				dec_ra  = la[AW-1:0];
			end
			OP_PRINT: begin
				dec_nrd = 2'd1;
				if (item_q.pop_print) begin
					if (sp_q == '0) dec_err = ERR_STACK;
				end else begin
					if (!la_ok) dec_err = ERR_STACK;
					dec_ra = la[AW-1:0];
				end
			end
			OP_ENTRY: begin
				dec_nrd = 2'd0;
			end
			OP_RET: begin
				if (sp_q == '0 || fp_q == '0) dec_err = ERR_STACK;
				dec_nrd = 2'd3;
				dec_rb  = fp_m1[AW-1:0];
			end
			OP_FRAME: begin
				if (full || nsp_f < XW'(0) || nsp_f > DEPTHX) dec_err = ERR_STACK;
			end
			OP_POPR: begin
				if (nsp_p < XW'(0) || nsp_p >= DEPTHX) dec_err = ERR_STACK;
				dec_wa = nsp_p[AW-1:0];
			end
			default: begin
				dec_err = ERR_OP;
			end
		endcase
	end

	assign dec_read = !halt_q && dec_err == ERR_NONE && dec_nrd != 2'd0;

	// arithmetic result, x below y on the stack
	always_comb begin
		case (item_q.op)
			OP_ADD:  res = sat32(64'($signed(b_q)) + 64'($signed(a_q)));
			OP_SUB:  res = sat32(64'($signed(b_q)) - 64'($signed(a_q)));
			OP_MUL:  res = sat32(prod_q >>> FRAC_BITS);
			OP_DIV: begin
				if (a_q != '0) begin
					res = div_q;
				end else if ($signed(b_q) > 0) begin
					res = 32'sh7FFF_FFFF;
				end else if ($signed(b_q) < 0) begin
					res = 32'sh8000_0000;
				end else begin
					res = '0;
				end
			end
			default: res = '0;
		endcase
	end

	assign link_bad = b_q[DATA_W-1] || XW'($signed(b_q)) > DEPTHX;
	assign div_start = (state_q == S_EX) && (item_q.op == OP_DIV) && (a_q != '0);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: if (q_pop) state_n = S_DEC;
			S_DEC:  state_n = dec_read ? S_RA : S_IDLE;
			S_RA:   state_n = (nrd_q >= 2'd2) ? S_RB : S_CAP;
			S_RB:   state_n = (nrd_q == 2'd3) ? S_RC : S_CAP;
			S_RC:   state_n = S_CAP;
			S_CAP:  state_n = S_EX;
			S_EX: begin
				if (item_q.op == OP_MUL) begin
					state_n = S_MUL;
				end else if (div_start) begin
					state_n = S_DIV;
				end else begin
					state_n = S_IDLE;
				end
			end
			S_MUL:  state_n = S_IDLE;
			S_DIV:  if (div_done) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// read address
	always_comb begin
		case (state_q)
			S_RB:    rd_addr = rb_q;
			S_RC:    rd_addr = rc_q;
			default: rd_addr = ra_q;
		endcase
	end

	// commit of one instruction
	always_comb begin
		cm_do   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = sp_q[AW-1:0];
		wr_data = item_q.operand;
		sp_n    = sp_q;
		fp_n    = fp_q;
		pc_n    = pc_q;
		lp_n    = lp_q;
		halt_n  = halt_q;
		seq     = 1'b1;
		printed = 1'b0;
		pv      = '0;
		err     = ERR_NONE;
		npc     = {1'b0, pc_q} + (PW+1)'(1);
		case (state_q)
			S_DEC: begin
				cm_do = !dec_read;
				if (halt_q) begin
					seq = 1'b0;
				end else if (dec_err != ERR_NONE) begin
					err = dec_err;
				end else begin
					case (item_q.op)
						OP_PUSH: begin
							wr_en = cm_do;
							sp_n  = sp_q + SW'(1);
						end
						OP_FRAME: begin
							wr_en   = cm_do;
							wr_data = DATA_W'(fp_q);
							fp_n    = sp_q + SW'(1);
							sp_n    = nsp_f[SW-1:0];
						end
						OP_CALL: begin
							wr_en   = cm_do;
							wr_data = DATA_W'(pc_q) + DATA_W'(1);
							sp_n    = sp_q + SW'(1);
							pc_n    = item_q.ip[PW-1:0];
							seq     = 1'b0;
						end
						OP_POPR: begin
							wr_en   = cm_do;
							wr_addr = nsp_p[AW-1:0];
							wr_data = lp_q;
							sp_n    = nsp_p[SW-1:0] + SW'(1);
						end
						default: begin
							wr_en = 1'b0;
						end
					endcase
				end
			end
			S_EX, S_MUL, S_DIV: begin
				cm_do = (state_q == S_EX && item_q.op != OP_MUL && !div_start) ||
					state_q == S_MUL || (state_q == S_DIV && div_done);
				lp_n = a_q;
				case (item_q.op)
					OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
						wr_en   = cm_do;
						wr_addr = wa_q;
						wr_data = res;
						sp_n    = sp_m1;
						if (item_q.op == OP_DIV && a_q == '0) err = ERR_DIV;
					end
					OP_STOREL, OP_STOREA: begin
						wr_en   = cm_do;
						wr_addr = wa_q;
						wr_data = a_q;
						sp_n    = sp_m1;
					end
					OP_LOADL, OP_LOADA: begin
						wr_en   = cm_do;
						wr_addr = wa_q;
						wr_data = a_q;
						sp_n    = sp_q + SW'(1);
					end
					OP_PRINT: begin
						printed = 1'b1;
						pv      = a_q;
						if (item_q.pop_print) sp_n = sp_m1;
					end
					OP_RET: begin
						fp_n = link_bad ? SW'(STACK_DEPTH) : b_q[SW-1:0];
						seq  = 1'b0;
						if (fp_q == SW'(1)) begin
							sp_n   = '0;
							halt_n = 1'b1;
						end else begin
							sp_n = fp_m2;
							pc_n = c_q[PW-1:0];
						end
					end
					default: begin
						lp_n = lp_q;
					end
				endcase
			end
			default: begin
				cm_do = 1'b0;
			end
		endcase
		// step to the next instruction
		if (seq) begin
			pc_n = npc[PW-1:0];
			if (EW'(npc) > EW'(cfg.program_end)) halt_n = 1'b1;
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			fp_q        <= '0;
			pc_q        <= '0;
			lp_q        <= '0;
			halt_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cm_do) begin
				sp_q   <= sp_n;
				fp_q   <= fp_n;
				pc_q   <= pc_n;
				lp_q   <= lp_n;
				halt_q <= halt_n;
			end else if (cfg.pc_load) begin
				pc_q <= PW'((PW + CFG_W)'(cfg.pc_value));
			end
			if (cm_do) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// work and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == S_DEC) begin
			ra_q  <= dec_ra;
			rb_q  <= dec_rb;
			rc_q  <= dec_rc;
			wa_q  <= dec_wa;
			nrd_q <= dec_nrd;
		end
		if (state_q == S_RB) begin
			a_q <= rd_data;
		end
		if (state_q == S_RC) begin
			b_q <= rd_data;
		end
		if (state_q == S_CAP) begin
			case (nrd_q)
				2'd1:    a_q <= rd_data;
				2'd2:    b_q <= rd_data;
				default: c_q <= rd_data;
			endcase
		end
		if (state_q == S_EX) begin
			prod_q <= 64'($signed(b_q)) * 64'($signed(a_q));
		end
		if (cm_do) begin
			out_pc_q    <= pc_n;
			out_print_q <= printed;
			out_pv_q    <= pv;
			out_halt_q  <= halt_n;
			out_err_q   <= err;
		end
	end

	assign out_valid   = out_valid_q;
	assign next_pc     = out_pc_q;
	assign print_valid = out_print_q;
	assign print_value = $signed(out_pv_q);
	assign halted      = out_halt_q;
	assign error_code  = out_err_q;

	// stack pointer stays inside the memory plus one
	assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SW'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	// once halted, the halt flag stays set
	assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared");

	// an instruction only commits while the result slot is free
	assert property (@(posedge clk) disable iff (!arst_n)
		cm_do |-> !out_valid_q)
		else $error("result overwritten before taken");

	// stack writes only happen when an instruction commits
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> cm_do && !halt_q)
		else $error("stray stack write");

	// a printing word never reports an error
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_print_q |-> out_err_q == ERR_NONE)
		else $error("print with error code");

endmodule

`default_nettype wire

>>> src/stack_machine_executor.sv
// stack machine executor top: front queue (smx_front) feeding the back end (smx_back)
// push, call, frame, popr, entry, faults and halted words commit at decode with no
// stack read; loads, stores, print, add/sub, mul, ret and div read operands first,
// div then waits on the divider; a new word is taken once the last has committed;
// stack reads on one read port and the one-bit-per-cycle divider set the cost.
// reset clears pointers, pc, halt, config and queue; stack contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_executor #(
	parameter int STACK_DEPTH   = smx_pkg::DEF_STACK_DEPTH,
	parameter int PROGRAM_DEPTH = smx_pkg::DEF_PROGRAM_DEPTH,
	parameter int FRAC_BITS     = smx_pkg::DEF_FRAC_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [smx_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [smx_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [smx_pkg::OP_W-1:0]            cmd,
	input  wire logic signed [smx_pkg::DATA_W-1:0]   operand,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [$clog2(PROGRAM_DEPTH)-1:0]         next_pc,
	output logic                                     print_valid,
	output logic signed [smx_pkg::DATA_W-1:0]        print_value,
	output logic                                     halted,
	output logic [1:0]                               error_code
);
	import smx_pkg::*;

	logic             q_valid;
	logic             q_pop;
	item_t            q_item;
	cfg_t             cfg;
	logic [CFG_W-1:0] program_end_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_end_q <= '0;
		end else if (cfg_we && cfg_index == CFG_PROGRAM_END) begin
			program_end_q <= cfg_data;
		end
	end

	always_comb begin
		cfg.pc_load     = cfg_we && cfg_index == CFG_START_PC;
		cfg.pc_value    = cfg_data;
		cfg.program_end = program_end_q;
	end

	smx_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd     (cmd),
		.operand (operand),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	smx_back #(
		.STACK_DEPTH  (STACK_DEPTH),
		.PROGRAM_DEPTH(PROGRAM_DEPTH),
		.FRAC_BITS    (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.cfg        (cfg),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.next_pc    (next_pc),
		.print_valid(print_valid),
		.print_value(print_value),
		.halted     (halted),
		.error_code (error_code)
	);

endmodule

`default_nettype wire

>>> dv/smx_result_checker.sv
// result checker for the stack machine executor: tracks config writes and accepted
// instruction words, predicts each result word and compares it with the block output
// depends on smx_pkg
`timescale 1ns / 1ps

module smx_result_checker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [0:0]           cfg_index,
	input  wire logic [6:0]           cfg_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire logic [3:0]           cmd,
	input  wire logic signed [31:0]   operand,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire logic [6:0]           next_pc,
	input  wire logic                 print_valid,
	input  wire logic signed [31:0]   print_value,
	input  wire logic                 halted,
	input  wire logic [1:0]           error_code,
	output int                        mismatches,
	output int                        outstanding,
	output int                        depth_now
);
	import smx_pkg::*;

	localparam longint DEPTH = 256;
	localparam logic signed [31:0] POP_PRINT = 32'shFFFF_0000;

	typedef struct packed {
		logic [6:0]  pc;
		logic        pv;
		logic [31:0] val;
		logic        h;
		logic [1:0]  err;
	} step_result_t;

	// machine state mirrored from the instruction stream
	logic signed [31:0] stk [0:255];
	longint sp, fp, pc;
	logic signed [31:0] last_val;
	bit halt;
	logic [6:0] pend;
	step_result_t pending_results [$];

	function automatic logic signed [31:0] clamp_word(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// execute one instruction word and queue its result word
	task automatic execute_word(input logic [3:0] c, input logic signed [31:0] o);
		longint w, ip, addr, nsp, link, npc, x, y, p, s;
		logic signed [31:0] r;
		step_result_t e;
		bit seq;
		e = '0;
		seq = 1;
		w = o;
		ip = (w < 0) ? -((-w) >>> 16) : (w >>> 16);
		if (halt) begin
			e.pc = pc[6:0];
			e.h = 1'b1;
			pending_results.push_back(e);
			return;
		end
		case (c)
			OP_PUSH: begin
				if (sp >= DEPTH) begin
					e.err = ERR_STACK;
				end else begin
					stk[sp] = o;
					sp++;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (sp < 2) begin
					e.err = ERR_STACK;
				end else begin
					y = stk[sp-1];
					x = stk[sp-2];
					if (c == OP_ADD) begin
						r = clamp_word(x + y);
					end else if (c == OP_SUB) begin
						r = clamp_word(x - y);
					end else if (c == OP_MUL) begin
						p = x * y;
						// product rounds toward minus infinity
						r = (p < 0) ? clamp_word(-(((-p) + 65535) >>> 16))
						            : clamp_word(p >>> 16);
					end else if (y == 0) begin
						e.err = ERR_DIV;
						r = (x > 0) ? 32'sh7FFF_FFFF : ((x < 0) ? 32'sh8000_0000 : 32'sd0);
					end else begin
						r = clamp_word((x * 65536) / y);
					end
					stk[sp-2] = r;
					sp--;
					last_val = y[31:0];
				end
			end
			OP_STOREL, OP_STOREA: begin
				addr = (c == OP_STOREL) ? fp + ip : fp - ip - 3;
				if (sp < 1 || addr < 0 || addr >= DEPTH) begin
					e.err = ERR_STACK;
				end else begin
					last_val = stk[sp-1];
					sp--;
					stk[addr] = last_val;
				end
			end
			OP_LOADL, OP_LOADA: begin
				addr = (c == OP_LOADL) ? fp + ip : fp - ip - 3;
				if (sp >= DEPTH || addr < 0 || addr >= DEPTH) begin
					e.err = ERR_STACK;
				end else begin
					last_val = stk[addr];
					stk[sp] = last_val;
					sp++;
				end
			end
			OP_PRINT: begin
				// minus one pops, anything else reads a local
				if (o == POP_PRINT) begin
					if (sp < 1) begin
						e.err = ERR_STACK;
					end else begin
						last_val = stk[sp-1];
						sp--;
						e.pv = 1'b1;
					end
				end else begin
					addr = fp + ip;
					if (addr < 0 || addr >= DEPTH) begin
						e.err = ERR_STACK;
					end else begin
						last_val = stk[addr];
						e.pv = 1'b1;
					end
				end
				if (e.pv) e.val = last_val;
			end
			OP_ENTRY: begin
			end
			OP_RET: begin
				if (sp < 1 || fp < 1) begin
					e.err = ERR_STACK;
				end else begin
					last_val = stk[sp-1];
					s = fp - 1;
					link = stk[s];
					fp = (link < 0 || link > DEPTH) ? DEPTH : link;
					seq = 0;
					if (s <= 0) begin
						// empty frame ends the program
						sp = 0;
						halt = 1;
					end else begin
						s--;
						pc = stk[s][6:0];
						sp = s;
					end
				end
			end
			OP_FRAME: begin
				nsp = sp + 1 + ip;
				if (sp >= DEPTH || nsp < 0 || nsp > DEPTH) begin
					e.err = ERR_STACK;
				end else begin
					stk[sp] = fp[31:0];
					fp = sp + 1;
					sp = nsp;
				end
			end
			OP_CALL: begin
				if (sp >= DEPTH) begin
					e.err = ERR_STACK;
				end else begin
					stk[sp] = pc[31:0] + 32'd1;
					sp++;
					pc = ip[6:0];
					seq = 0;
				end
			end
			OP_POPR: begin
				nsp = sp - ip;
				if (nsp < 0 || nsp >= DEPTH) begin
					e.err = ERR_STACK;
				end else begin
					stk[nsp] = last_val;
					sp = nsp + 1;
				end
			end
			default: e.err = ERR_OP;
		endcase
		if (seq) begin
			npc = pc + 1;
			if (npc > pend) halt = 1;
			pc = npc % 128;
		end
		e.pc = pc[6:0];
		e.h = halt;
		pending_results.push_back(e);
	endtask

	// watch both channels and the config port
	always @(posedge clk or negedge arst_n) begin
		step_result_t e, got;
		if (!arst_n) begin
			sp = 0;
			fp = 0;
			pc = 0;
			last_val = '0;
			halt = 0;
			pend = '0;
			pending_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_START_PC) begin
					pc = cfg_data;
				end else begin
					pend = cfg_data;
				end
			end
			if (in_valid && !in_stall) execute_word(cmd, operand);
			if (out_valid && !out_stall) begin
				got = '{next_pc, print_valid, print_value, halted, error_code};
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%t: result word with none expected, got pc=%0d pv=%0b val=%h halt=%0b err=%0d",
						$time, got.pc, got.pv, got.val, got.h, got.err);
				end else begin
					e = pending_results.pop_front();
					if (got !== e) begin
						mismatches++;
						$display("%t: mismatch expected pc=%0d pv=%0b val=%h halt=%0b err=%0d",
							$time, e.pc, e.pv, e.val, e.h, e.err);
						$display("%t:          actual   pc=%0d pv=%0b val=%h halt=%0b err=%0d",
							$time, got.pc, got.pv, got.val, got.h, got.err);
					end
				end
			end
		end
		outstanding = pending_results.size();
		depth_now = int'(sp);
	end

endmodule

>>> dv/stack_machine_executor_tb.sv
// testbench top for the stack machine executor: clock, reset, instruction
// stimulus and verdict; depends on smx_pkg, smx_result_checker and the block
`timescale 1ns / 1ps

module stack_machine_executor_tb;
	import smx_pkg::*;

	localparam logic signed [31:0] POP_PRINT = 32'shFFFF_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_START_PC;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] cmd = OP_ENTRY;
	logic signed [DATA_W-1:0] operand = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [6:0] next_pc;
	logic print_valid;
	logic signed [DATA_W-1:0] print_value;
	logic halted;
	logic [1:0] error_code;
	int mismatches, outstanding, depth_now;

	int words_sent = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;

	stack_machine_executor dut (.*);
	smx_result_checker checker_i (.*);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// receiver stall pattern: free, light or heavy stretches
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	function automatic logic signed [31:0] fx(input int n);
		return n <<< 16;
	endfunction

	// one instruction word, held until accepted, then maybe a gap
	task automatic send(input logic [3:0] c, input logic signed [31:0] o);
		cmd <= c;
		operand <= o;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		words_sent++;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 24);
		end else begin
			burst_left--;
		end
	endtask

	// stop sending and wait for every result word
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic restart(input logic [CFG_W-1:0] entry, input logic [CFG_W-1:0] last);
		settle();
		write_reg(CFG_PROGRAM_END, last);
		write_reg(CFG_START_PC, entry);
	endtask

	// well formed call, frame, body and return
	task automatic run_function();
		int n, d, k, pick;
		n = $urandom_range(2, 4);
		d = n;
		send(OP_CALL, fx($urandom_range(0, 15)) | $urandom_range(0, 65535));
		send(OP_FRAME, fx(n) | $urandom_range(0, 65535));
		k = $urandom_range(3, 10);
		repeat (k) begin
			pick = (d < 3) ? $urandom_range(0, 3) : $urandom_range(0, 8);
			case (pick)
				0: begin send(OP_PUSH, $urandom()); d++; end
				1: begin send(OP_LOADL, fx($urandom_range(0, n - 1))); d++; end
				2: begin send(OP_LOADA, fx($urandom_range(0, 2))); d++; end
				3: begin send(OP_POPR, fx(0)); d++; end
				4: begin send(op_t'($urandom_range(OP_ADD, OP_DIV)), $urandom()); d--; end
				5: begin send(OP_STOREL, fx($urandom_range(0, n - 1))); d--; end
				6: begin send(OP_PRINT, POP_PRINT); d--; end
				7: send(OP_POPR, fx(1));
				default: send(OP_PRINT, fx($urandom_range(0, n - 1)));
			endcase
		end
		send(OP_RET, $urandom());
	endtask

	// unstructured word; return is left to the well formed sequences
	task automatic noise_word();
		logic [3:0] c;
		logic signed [31:0] o;
		c = $urandom_range(0, 15);
		if (c == OP_RET) c = OP_ENTRY;
		case ($urandom_range(0, 3))
			0: o = $urandom();
			1: o = POP_PRINT;
			default: o = fx($urandom_range(0, 24) - 4) | $urandom_range(0, 65535);
		endcase
		if (c == OP_CALL) o = fx($urandom_range(0, 15));
		send(c, o);
	endtask

	initial begin
		int budget;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// write every stack entry, one push past full, then drop to two
		for (int i = 0; i < 257; i++) begin
			if (i % 100 == 0) restart('0, 7'd127);
			if (i == 0) send(OP_PUSH, 32'sh7FFF_FFFF);
			else if (i == 1) send(OP_PUSH, 32'sh8000_0000);
			else send(OP_PUSH, $urandom());
		end
		send(OP_POPR, fx(255));
		restart('0, 7'd127);

		// directed: saturation, rounding, divide by zero, print forms, faults
		send(OP_PUSH, 32'sh7FFF_FFFF); send(OP_PUSH, fx(1)); send(OP_ADD, '0);
		send(OP_PUSH, 32'sh8000_0000); send(OP_SUB, '0);
		send(OP_PUSH, 32'sh0000_0001); send(OP_PUSH, 32'shFFFF_FFFF); send(OP_MUL, '0);
		send(OP_PUSH, fx(0)); send(OP_DIV, '0);
		send(OP_PUSH, fx(-5)); send(OP_PUSH, fx(0)); send(OP_DIV, '0);
		send(OP_PUSH, fx(7)); send(OP_PUSH, fx(-2)); send(OP_DIV, '0);
		send(OP_PRINT, POP_PRINT); send(OP_PRINT, fx(1)); send(OP_PRINT, fx(300));
		send(4'hF, $urandom()); send(OP_ENTRY, '0);
		send(OP_STOREL, fx(3)); send(OP_LOADL, -fx(1)); send(OP_LOADA, -fx(3));
		send(OP_STOREA, -fx(4)); send(OP_POPR, fx(2)); send(OP_FRAME, -fx(1));

		// random phases from a fresh entry point
		while (words_sent < 1450) begin
			restart($urandom_range(0, 15), $urandom_range(115, 127));
			if (depth_now > 64) send(OP_POPR, fx(depth_now - 1));
			budget = words_sent + 78;
			while (words_sent < budget) begin
				if ($urandom_range(0, 3) == 0) run_function();
				else noise_word();
			end
		end

		// extreme entry point halts at once; everything after stays halted
		restart(7'd127, 7'd0);
		repeat (20) noise_word();

		settle();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("stack_machine_executor test passed");
		end else begin
			$display("stack_machine_executor test failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("stack_machine_executor test failed");
		$finish;
	end

endmodule

>>> sim.f
src/smx_pkg.sv
src/smx_ram.sv
src/smx_div.sv
src/smx_front.sv
src/smx_back.sv
src/stack_machine_executor.sv
dv/smx_result_checker.sv
dv/stack_machine_executor_tb.sv
